// File: rtl/hlts_pkg.sv
package hlts_pkg;

  localparam int DATA_W      = 32;
  localparam int GAIN_W      = 17;
  localparam int STEP_W      = 5;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 2;
  localparam int FRAC_W      = 16;
  localparam int MAX_HORIZON = 16;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_HORIZON);

  localparam int ACC_W  = DATA_W + $clog2(MAX_HORIZON + 1) + 1;
  localparam int DIFF_W = DATA_W + 2;
  localparam int PROD_W = GAIN_W + 1 + DIFF_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int RES_W  = RND_W - FRAC_W;
  localparam int WIDE_W = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATE   = 2'd0,
    KIND_FORECAST = 2'd1,
    KIND_RESTART  = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ALPHA      = 2'd0,
    REG_BETA       = 2'd1,
    REG_INIT_LEVEL = 2'd2,
    REG_INIT_TREND = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF_L,
    ST_MUL_L,
    ST_LEV,
    ST_DIFF_T,
    ST_MUL_T,
    ST_TRD,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic fc_run;
    logic load_init;
    logic diff_l;
    logic mul_l;
    logic lev;
    logic diff_t;
    logic mul_t;
    logic trd;
    logic load_fc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } stat_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    if ((x[WIDE_W-1:DATA_W-1] == '0) || (x[WIDE_W-1:DATA_W-1] == '1)) begin
      r.clip = 1'b0;
      r.val  = x[DATA_W-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // round half up, drop the fraction bits
  function automatic logic signed [RES_W-1:0] round_q16(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] y;
    y = x + RND_W'(1 << (FRAC_W - 1));
    return y[RND_W-1:FRAC_W];
  endfunction

endpackage

// File: rtl/hlts_ctrl.sv
module hlts_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [hlts_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  input  hlts_pkg::stat_t            stat,
  output hlts_pkg::cmd_t             cmd
);

  hlts_pkg::state_t state_r;
  hlts_pkg::state_t state_nxt;
  hlts_pkg::kind_t  kind;
  logic             accept;

  assign kind   = hlts_pkg::kind_t'(in_kind);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hlts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hlts_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            hlts_pkg::KIND_UPDATE:   state_nxt = hlts_pkg::ST_DIFF_L;
            hlts_pkg::KIND_FORECAST: state_nxt = hlts_pkg::ST_LOAD;
            hlts_pkg::KIND_RESTART:  state_nxt = hlts_pkg::ST_LOAD;
            default: state_nxt = hlts_pkg::ST_IDLE;
          endcase
        end
      end
      hlts_pkg::ST_DIFF_L: state_nxt = hlts_pkg::ST_MUL_L;
      hlts_pkg::ST_MUL_L:  state_nxt = hlts_pkg::ST_LEV;
      hlts_pkg::ST_LEV:    state_nxt = hlts_pkg::ST_DIFF_T;
      hlts_pkg::ST_DIFF_T: state_nxt = hlts_pkg::ST_MUL_T;
      hlts_pkg::ST_MUL_T:  state_nxt = hlts_pkg::ST_TRD;
      hlts_pkg::ST_TRD:    state_nxt = hlts_pkg::ST_LOAD;
      hlts_pkg::ST_LOAD:   state_nxt = hlts_pkg::ST_EMIT;
      hlts_pkg::ST_EMIT: begin
        if (stat.out_free && stat.last) begin
          state_nxt = hlts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hlts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      hlts_pkg::ST_IDLE: begin
        in_ready      = rst_n;
        cmd.capture   = accept;
        cmd.fc_run    = accept && (kind == hlts_pkg::KIND_FORECAST);
        cmd.load_init = accept && (kind == hlts_pkg::KIND_RESTART);
      end
      hlts_pkg::ST_DIFF_L: cmd.diff_l  = 1'b1;
      hlts_pkg::ST_MUL_L:  cmd.mul_l   = 1'b1;
      hlts_pkg::ST_LEV:    cmd.lev     = 1'b1;
      hlts_pkg::ST_DIFF_T: cmd.diff_t  = 1'b1;
      hlts_pkg::ST_MUL_T:  cmd.mul_t   = 1'b1;
      hlts_pkg::ST_TRD:    cmd.trd     = 1'b1;
      hlts_pkg::ST_LOAD:   cmd.load_fc = 1'b1;
      hlts_pkg::ST_EMIT:   cmd.emit    = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/hlts_dp.sv
module hlts_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hlts_pkg::cmd_t                      cmd,
  output hlts_pkg::stat_t                     stat,
  input  logic signed [hlts_pkg::DATA_W-1:0]  in_sample,
  input  logic [hlts_pkg::STEP_W-1:0]         in_horizon,
  input  logic                                cfg_valid,
  input  logic [hlts_pkg::IDX_W-1:0]          cfg_index,
  input  logic [hlts_pkg::DATA_W-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_level_out,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_trend_out,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_forecast_value,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_forecast_error,
  output logic [hlts_pkg::STEP_W-1:0]         out_steps_ahead,
  output logic                                out_last_of_run,
  output logic                                out_saturated
);

  logic [hlts_pkg::GAIN_W-1:0]        alpha_r;
  logic [hlts_pkg::GAIN_W-1:0]        beta_r;
  logic signed [hlts_pkg::DATA_W-1:0] init_level_r;
  logic signed [hlts_pkg::DATA_W-1:0] init_trend_r;

  logic signed [hlts_pkg::DATA_W-1:0] level_r;
  logic signed [hlts_pkg::DATA_W-1:0] trend_r;
  logic signed [hlts_pkg::DATA_W-1:0] sample_r;
  logic [hlts_pkg::STEP_W-1:0]        count_r;
  logic signed [hlts_pkg::DIFF_W-1:0] diff_r;
  logic signed [hlts_pkg::PROD_W-1:0] prod_r;
  logic signed [hlts_pkg::DATA_W-1:0] nl_r;
  logic signed [hlts_pkg::DATA_W-1:0] err_r;
  logic                               clip_r;
  logic signed [hlts_pkg::ACC_W-1:0]  acc_r;
  logic [hlts_pkg::STEP_W-1:0]        step_r;

  logic                               out_valid_r;
  logic signed [hlts_pkg::DATA_W-1:0] out_level_r;
  logic signed [hlts_pkg::DATA_W-1:0] out_trend_r;
  logic signed [hlts_pkg::DATA_W-1:0] out_fc_r;
  logic signed [hlts_pkg::DATA_W-1:0] out_err_r;
  logic [hlts_pkg::STEP_W-1:0]        out_step_r;
  logic                               out_last_r;
  logic                               out_sat_r;

  logic [hlts_pkg::GAIN_W-1:0]        gain_a;
  logic [hlts_pkg::GAIN_W-1:0]        gain_b;
  logic [hlts_pkg::GAIN_W-1:0]        mul_gain;
  logic signed [hlts_pkg::DATA_W:0]   sum_w;
  logic signed [hlts_pkg::DATA_W:0]   base_w;
  logic signed [hlts_pkg::DATA_W-1:0] diff_a;
  logic signed [hlts_pkg::DIFF_W-1:0] diff_nxt;
  logic signed [hlts_pkg::PROD_W-1:0] prod_nxt;
  logic signed [hlts_pkg::DATA_W:0]   err_full;
  logic signed [hlts_pkg::RND_W-1:0]  rnd_x;
  logic signed [hlts_pkg::RES_W-1:0]  rnd_q;
  logic [hlts_pkg::STEP_W-1:0]        count_nxt;
  hlts_pkg::sat_t                     old_s;
  hlts_pkg::sat_t                     err_s;
  hlts_pkg::sat_t                     rnd_s;
  hlts_pkg::sat_t                     fc_s;

  assign gain_a   = (alpha_r > hlts_pkg::GAIN_ONE) ? hlts_pkg::GAIN_ONE : alpha_r;
  assign gain_b   = (beta_r > hlts_pkg::GAIN_ONE) ? hlts_pkg::GAIN_ONE : beta_r;
  assign mul_gain = cmd.mul_t ? gain_b : gain_a;

  assign sum_w    = (hlts_pkg::DATA_W + 1)'(level_r) + (hlts_pkg::DATA_W + 1)'(trend_r);
  assign diff_a   = cmd.diff_t ? nl_r : sample_r;
  assign diff_nxt = hlts_pkg::DIFF_W'(diff_a) - hlts_pkg::DIFF_W'(sum_w);
  assign prod_nxt = $signed({1'b0, mul_gain}) * diff_r;

  assign old_s    = hlts_pkg::sat_wide(hlts_pkg::WIDE_W'(sum_w));
  assign err_full = (hlts_pkg::DATA_W + 1)'(old_s.val) - (hlts_pkg::DATA_W + 1)'(sample_r);
  assign err_s    = hlts_pkg::sat_wide(hlts_pkg::WIDE_W'(err_full));

  // x*g + y*(1-g) rewritten as y + g*(x-y)
  assign base_w = cmd.trd ? (hlts_pkg::DATA_W + 1)'(trend_r) : sum_w;
  assign rnd_x  = (hlts_pkg::RND_W'(base_w) <<< hlts_pkg::FRAC_W)
                + hlts_pkg::RND_W'(prod_r);
  assign rnd_q  = hlts_pkg::round_q16(rnd_x);
  assign rnd_s  = hlts_pkg::sat_wide(hlts_pkg::WIDE_W'(rnd_q));

  assign fc_s   = hlts_pkg::sat_wide(hlts_pkg::WIDE_W'(acc_r));

  always_comb begin
    if (in_horizon == '0) begin
      count_nxt = hlts_pkg::STEP_W'(1);
    end else if (in_horizon > hlts_pkg::STEP_MAX) begin
      count_nxt = hlts_pkg::STEP_MAX;
    end else begin
      count_nxt = in_horizon;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.last     = (step_r == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= '0;
      beta_r       <= '0;
      init_level_r <= '0;
      init_trend_r <= '0;
    end else if (cfg_valid) begin
      unique case (hlts_pkg::cfg_reg_t'(cfg_index))
        hlts_pkg::REG_ALPHA:      alpha_r      <= cfg_data[hlts_pkg::GAIN_W-1:0];
        hlts_pkg::REG_BETA:       beta_r       <= cfg_data[hlts_pkg::GAIN_W-1:0];
        hlts_pkg::REG_INIT_LEVEL: init_level_r <= cfg_data;
        hlts_pkg::REG_INIT_TREND: init_trend_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      trend_r <= '0;
    end else if (cmd.load_init) begin
      level_r <= init_level_r;
      trend_r <= init_trend_r;
    end else if (cmd.trd) begin
      level_r <= nl_r;
      trend_r <= rnd_s.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      count_r  <= cmd.fc_run ? count_nxt : hlts_pkg::STEP_W'(1);
      err_r    <= '0;
      clip_r   <= 1'b0;
    end
    if (cmd.diff_l) begin
      err_r  <= err_s.val;
      clip_r <= old_s.clip | err_s.clip;
    end
    if (cmd.diff_l || cmd.diff_t) begin
      diff_r <= diff_nxt;
    end
    if (cmd.mul_l || cmd.mul_t) begin
      prod_r <= prod_nxt;
    end
    if (cmd.lev) begin
      nl_r   <= rnd_s.val;
      clip_r <= clip_r | rnd_s.clip;
    end
    if (cmd.trd) begin
      clip_r <= clip_r | rnd_s.clip;
    end
    if (cmd.load_fc) begin
      acc_r  <= hlts_pkg::ACC_W'(level_r) + hlts_pkg::ACC_W'(trend_r);
      step_r <= hlts_pkg::STEP_W'(1);
    end
    if (cmd.emit) begin
      out_level_r <= level_r;
      out_trend_r <= trend_r;
      out_fc_r    <= fc_s.val;
      out_err_r   <= err_r;
      out_step_r  <= step_r;
      out_last_r  <= stat.last;
      out_sat_r   <= clip_r | fc_s.clip;
      acc_r       <= acc_r + hlts_pkg::ACC_W'(trend_r);
      step_r      <= step_r + hlts_pkg::STEP_W'(1);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_level_out      = out_level_r;
  assign out_trend_out      = out_trend_r;
  assign out_forecast_value = out_fc_r;
  assign out_forecast_error = out_err_r;
  assign out_steps_ahead    = out_step_r;
  assign out_last_of_run    = out_last_r;
  assign out_saturated      = out_sat_r;

endmodule

// File: rtl/holt_linear_trend_smoother.sv
// channel | direction | handshake          | word
// in      | input     | in_valid/in_ready   | kind, sample, horizon
// out     | output    | out_valid/out_ready | level, trend, forecast, error, steps, last, sat
// cfg     | input     | cfg_valid/cfg_ready | register index, write data
//
// update: states DIFF_L, MUL_L, LEV, DIFF_T, MUL_T, TRD, LOAD, EMIT, two passes through one
//   18x34 multiplier
// forecast run: one result a cycle unless out_ready stalls, from an add-trend accumulator
// restart: loads the initial values; in_ready is high only while no item is in flight
// synchronous active-low reset clears level, trend, gains and initial values
// out_ready low holds the result register and stalls the run; cfg_ready is high out of reset
module holt_linear_trend_smoother (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hlts_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [hlts_pkg::DATA_W-1:0]  in_sample,
  input  logic [hlts_pkg::STEP_W-1:0]         in_horizon,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_level_out,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_trend_out,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_forecast_value,
  output logic signed [hlts_pkg::DATA_W-1:0]  out_forecast_error,
  output logic [hlts_pkg::STEP_W-1:0]         out_steps_ahead,
  output logic                                out_last_of_run,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hlts_pkg::IDX_W-1:0]          cfg_index,
  input  logic [hlts_pkg::DATA_W-1:0]         cfg_data
);

  hlts_pkg::cmd_t  cmd;
  hlts_pkg::stat_t stat;

  assign cfg_ready = rst_n;

  hlts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hlts_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_sample          (in_sample),
    .in_horizon         (in_horizon),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_level_out      (out_level_out),
    .out_trend_out      (out_trend_out),
    .out_forecast_value (out_forecast_value),
    .out_forecast_error (out_forecast_error),
    .out_steps_ahead    (out_steps_ahead),
    .out_last_of_run    (out_last_of_run),
    .out_saturated      (out_saturated)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind != hlts_pkg::KIND_UNUSED)) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> out_valid)
    else $error("forecast run ended without a last word");

  a_error_on_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_forecast_error != '0)) |->
      ((out_steps_ahead == hlts_pkg::STEP_W'(1)) && out_last_of_run))
    else $error("nonzero error on a forecast run word");

  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_steps_ahead != '0) && (out_steps_ahead <= hlts_pkg::STEP_MAX)))
    else $error("steps ahead out of range");

endmodule

// File: dv/holt_linear_trend_smoother_tb.sv
import hlts_pkg::*;

typedef struct {
  logic signed [DATA_W-1:0] level;
  logic signed [DATA_W-1:0] trend;
  logic signed [DATA_W-1:0] forecast;
  logic signed [DATA_W-1:0] error;
  logic [STEP_W-1:0]        steps;
  logic                     last;
  logic                     clip;
} smoother_word_t;

class holt_scoreboard;
  logic [GAIN_W-1:0]        alpha;
  logic [GAIN_W-1:0]        beta;
  logic signed [DATA_W-1:0] init_level;
  logic signed [DATA_W-1:0] init_trend;
  logic signed [DATA_W-1:0] level;
  logic signed [DATA_W-1:0] trend;
  smoother_word_t           expected_q[$];
  int                       errors;

  function new();
    alpha      = '0;
    beta       = '0;
    init_level = '0;
    init_trend = '0;
    level      = '0;
    trend      = '0;
    errors     = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_ALPHA:      alpha = data[GAIN_W-1:0];
      REG_BETA:       beta = data[GAIN_W-1:0];
      REG_INIT_LEVEL: init_level = data;
      REG_INIT_TREND: init_trend = data;
      default: ;
    endcase
  endfunction

  function longint clamp32(longint x, inout bit clip);
    if (x > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // drop 16 fraction bits, half up
  function longint round_q16(longint x);
    return (x + 64'sd32768) >>> FRAC_W;
  endfunction

  function longint eff_gain(logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
  endfunction

  function void push_word(longint lv, longint tr, longint fc, longint er, int steps,
                          bit last, bit clip);
    smoother_word_t w;
    w.level    = lv[DATA_W-1:0];
    w.trend    = tr[DATA_W-1:0];
    w.forecast = fc[DATA_W-1:0];
    w.error    = er[DATA_W-1:0];
    w.steps    = steps[STEP_W-1:0];
    w.last     = last;
    w.clip     = clip;
    expected_q.insert(expected_q.size(), w);
  endfunction

  function void note_word(kind_t kind, logic signed [DATA_W-1:0] sample,
                          logic [STEP_W-1:0] horizon);
    bit     clip;
    longint a, b, sum, old_fc, err, nl, nt, fc;
    int     n;
    case (kind)
      KIND_UPDATE: begin
        clip   = 1'b0;
        a      = eff_gain(alpha);
        b      = eff_gain(beta);
        sum    = longint'(level) + longint'(trend);
        old_fc = clamp32(sum, clip);
        err    = clamp32(old_fc - longint'(sample), clip);
        nl     = clamp32(round_q16(a * longint'(sample) + (64'sd65536 - a) * sum), clip);
        nt     = clamp32(round_q16(b * (nl - longint'(level)) +
                                   (64'sd65536 - b) * longint'(trend)), clip);
        level  = nl[DATA_W-1:0];
        trend  = nt[DATA_W-1:0];
        fc     = clamp32(nl + nt, clip);
        push_word(nl, nt, fc, err, 1, 1'b1, clip);
      end
      KIND_FORECAST: begin
        n = horizon;
        if (n == 0) n = 1;
        if (n > MAX_HORIZON) n = MAX_HORIZON;
        for (int h = 1; h <= n; h++) begin
          clip = 1'b0;
          fc   = clamp32(longint'(level) + longint'(h) * longint'(trend), clip);
          push_word(level, trend, fc, 0, h, h == n, clip);
        end
      end
      KIND_RESTART: begin
        clip  = 1'b0;
        level = init_level;
        trend = init_trend;
        fc    = clamp32(longint'(level) + longint'(trend), clip);
        push_word(level, trend, fc, 0, 1, 1'b1, clip);
      end
      default: ;
    endcase
  endfunction

  function void match(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  function void check_word(smoother_word_t got);
    smoother_word_t want;
    if (expected_q.size() == 0) begin
      $display("%0t unexpected word: level %0d trend %0d forecast %0d steps %0d",
               $time, got.level, got.trend, got.forecast, got.steps);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    match("level_out", want.level, got.level);
    match("trend_out", want.trend, got.trend);
    match("forecast_value", want.forecast, got.forecast);
    match("forecast_error", want.error, got.error);
    match("steps_ahead", want.steps, got.steps);
    match("last_of_run", want.last, got.last);
    match("saturated", want.clip, got.clip);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module holt_linear_trend_smoother_tb;
  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [DATA_W-1:0] in_sample = '0;
  logic [STEP_W-1:0]        in_horizon = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_level_out;
  logic signed [DATA_W-1:0] out_trend_out;
  logic signed [DATA_W-1:0] out_forecast_value;
  logic signed [DATA_W-1:0] out_forecast_error;
  logic [STEP_W-1:0]        out_steps_ahead;
  logic                     out_last_of_run;
  logic                     out_saturated;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  holt_scoreboard sb;
  bit             no_idle = 1'b0;

  holt_linear_trend_smoother uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_sample          (in_sample),
    .in_horizon         (in_horizon),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_level_out      (out_level_out),
    .out_trend_out      (out_trend_out),
    .out_forecast_value (out_forecast_value),
    .out_forecast_error (out_forecast_error),
    .out_steps_ahead    (out_steps_ahead),
    .out_last_of_run    (out_last_of_run),
    .out_saturated      (out_saturated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic send_word(kind_t kind, logic [DATA_W-1:0] sample, logic [STEP_W-1:0] horizon);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_sample  <= sample;
    in_horizon <= horizon;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(kind, sample, horizon);
  endtask

  // drain every expected word, then cover items that give no word
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_regs(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                            logic [DATA_W-1:0] lv, logic [DATA_W-1:0] tr);
    logic [DATA_W-1:0] vals[4];
    vals = '{a, b, lv, tr};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DATA_W'(GAIN_ONE);
      2: return ($urandom() & 32'hFFFE_0000) | $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_signed(int span);
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic run_phase(int count);
    int                done;
    int                roll;
    kind_t             kind;
    logic [DATA_W-1:0] sample;
    logic [STEP_W-1:0] horizon;
    settle();
    write_regs(pick_gain(), pick_gain(), pick_signed(1 << 23), pick_signed(1 << 18));
    no_idle = ($urandom_range(0, 3) == 0);
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 58) kind = KIND_UPDATE;
      else if (roll < 80) kind = KIND_FORECAST;
      else if (roll < 94) kind = KIND_RESTART;
      else kind = KIND_UNUSED;
      if ($urandom_range(0, 5) == 0) sample = $urandom();
      else sample = sb.level + ($urandom_range(0, 1 << 21) - (1 << 20));
      if ($urandom_range(0, 7) == 0) horizon = STEP_W'($urandom_range(0, 31));
      else horizon = STEP_W'($urandom_range(1, MAX_HORIZON));
      if (kind != KIND_UNUSED) done++;
      send_word(kind, sample, horizon);
    end
  endtask

  initial begin : result_side
    int             stall;
    smoother_word_t got;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.level    = out_level_out;
      got.trend    = out_trend_out;
      got.forecast = out_forecast_value;
      got.error    = out_forecast_error;
      got.steps    = out_steps_ahead;
      got.last     = out_last_of_run;
      got.clip     = out_saturated;
      sb.check_word(got);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // half alpha, quarter beta, ordinary start
    write_regs(32'h0000_8000, 32'h0000_4000, 32'h0001_0000, 32'h0000_8000);
    send_word(KIND_RESTART, $urandom(), 5'd1);
    send_word(KIND_UPDATE, 32'h0003_0000, 5'd1);
    send_word(KIND_UPDATE, 32'h7FFF_FFFF, 5'd1);
    send_word(KIND_UPDATE, 32'h8000_0000, 5'd1);
    send_word(KIND_UPDATE, 32'h0000_0000, 5'd1);
    send_word(KIND_FORECAST, $urandom(), 5'd1);
    send_word(KIND_FORECAST, $urandom(), 5'd16);
    send_word(KIND_FORECAST, $urandom(), 5'd0);
    send_word(KIND_FORECAST, $urandom(), 5'd17);
    send_word(KIND_FORECAST, $urandom(), 5'd31);
    send_word(KIND_UNUSED, $urandom(), STEP_W'($urandom()));
    send_word(KIND_RESTART, $urandom(), 5'd1);

    // zero and unit gain, top of range
    settle();
    write_regs(32'h0000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(KIND_RESTART, $urandom(), 5'd1);
    send_word(KIND_FORECAST, $urandom(), 5'd16);
    send_word(KIND_UPDATE, 32'h8000_0000, 5'd1);
    send_word(KIND_UPDATE, 32'h7FFF_FFFF, 5'd1);

    // gains above one, bottom of range
    settle();
    write_regs(32'hFFFF_FFFF, 32'h0001_0001, 32'h8000_0000, 32'h8000_0000);
    send_word(KIND_RESTART, $urandom(), 5'd1);
    send_word(KIND_UPDATE, 32'h7FFF_FFFF, 5'd1);
    send_word(KIND_FORECAST, $urandom(), 5'd31);
    send_word(KIND_UPDATE, 32'h1234_5678, 5'd1);
    send_word(KIND_RESTART, $urandom(), 5'd1);

    settle();
    write_regs(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
    send_word(KIND_RESTART, $urandom(), 5'd1);
    send_word(KIND_UPDATE, 32'hFFFF_8000, 5'd1);
    send_word(KIND_FORECAST, $urandom(), 5'd8);

    repeat (6) run_phase(55);

    settle();
    no_idle = 1'b0;
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("holt_linear_trend_smoother_tb: PASS");
    end else begin
      $display("holt_linear_trend_smoother_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1_500_000;
    $display("holt_linear_trend_smoother_tb: FAIL");
    $finish;
  end
endmodule
